@@ hdl/sts_pkg.sv @@
package sts_pkg;

   localparam int LEN_W = 6;
   localparam int POS_W = 16;
   localparam int KW_NUM = 8;
   localparam int KW_MAX_LEN = 12;

   localparam logic [4:0] KIND_WORD   = 5'd0;
   localparam logic [4:0] KIND_NUMBER = 5'd1;
   localparam logic [4:0] KIND_KW_BASE = 5'd2;
   localparam logic [4:0] KIND_PUNCT_BASE = 5'd10;

   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_DIGIT    = 2'd1;
   localparam logic [1:0] ERR_UNFINISH = 2'd2;
   localparam logic [1:0] ERR_OVERFLOW = 2'd3;

   localparam logic [7:0] CH_QUOTE   = 8'h22;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;

   localparam logic [3:0] KW_LEN [KW_NUM] = '{4'd7, 4'd7, 4'd12, 4'd5, 4'd8, 4'd8, 4'd4, 4'd4};

   localparam logic [7:0] KW_CHARS [KW_NUM][KW_MAX_LEN] = '{
      '{8'h69, 8'h6D, 8'h70, 8'h72, 8'h69, 8'h6D, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h65, 8'h78, 8'h70, 8'h72, 8'h69, 8'h6D, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h63, 8'h68, 8'h72, 8'h6F, 8'h6E, 8'h6F, 8'h6D, 8'hC3, 8'hA8, 8'h74, 8'h72, 8'h65},
      '{8'h74, 8'h65, 8'h6D, 8'h70, 8'h73, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h66, 8'h6F, 8'h6E, 8'h63, 8'h74, 8'h69, 8'h6F, 8'h6E, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h72, 8'h65, 8'h74, 8'h6F, 8'h75, 8'h72, 8'h6E, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h76, 8'h72, 8'h61, 8'h69, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h66, 8'h61, 8'h75, 8'h78, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
   };

   typedef enum logic [3:0] {
      MODE_WORD = 4'b0001,
      MODE_LIT  = 4'b0010,
      MODE_NUM  = 4'b0100,
      MODE_HALT = 4'b1000
   } mode_type;

   // one queue entry: everything a single input byte asks the back end to emit
   typedef struct packed {
      logic             flush_en;
      logic [4:0]       flush_kind;
      logic [LEN_W-1:0] flush_len;
      logic [POS_W-1:0] flush_line;
      logic [POS_W-1:0] flush_col;
      logic             single_en;
      logic [4:0]       single_kind;
      logic [7:0]       single_byte;
      logic [1:0]       err_code;
      logic [POS_W-1:0] line;
      logic [POS_W-1:0] col;
   } cmd_type;

   function automatic logic [4:0] punct_kind(input logic [7:0] c);
      logic [4:0] k;
      case (c)
         8'h7B: k = 5'd10;
         8'h7D: k = 5'd11;
         8'h28: k = 5'd12;
         8'h29: k = 5'd13;
         8'h5B: k = 5'd14;
         8'h5D: k = 5'd15;
         8'h3D: k = 5'd16;
         8'h3B: k = 5'd17;
         8'h2C: k = 5'd18;
         8'h2B: k = 5'd19;
         8'h2D: k = 5'd20;
         8'h2F: k = 5'd21;
         8'h2A: k = 5'd22;
         8'h7E: k = 5'd23;
         8'h26: k = 5'd24;
         8'h7C: k = 5'd25;
         8'h5E: k = 5'd26;
         8'h3C: k = 5'd27;
         8'h3E: k = 5'd28;
         8'h0A: k = 5'd29;
         8'h3A: k = 5'd30;
         default: k = KIND_WORD;
      endcase
      return k;
   endfunction

   function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] v);
      return (v == {POS_W{1'b1}}) ? v : v + 1'b1;
   endfunction

endpackage

@@ hdl/sts_ram.sv @@
module sts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

@@ hdl/sts_front.sv @@
module sts_front #(
   parameter int WORD_MAX = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [7:0]                  req_char_code,
   input  logic                        req_final_byte,
   input  logic                        q_full,
   input  logic                        q_store_busy,
   output logic                        cmd_valid,
   output sts_pkg::cmd_type            cmd,
   output logic                        wr_en,
   output logic [$clog2(WORD_MAX)-1:0] wr_addr,
   output logic [7:0]                  wr_data
);

   localparam int AW = $clog2(WORD_MAX);
   localparam int LW = sts_pkg::LEN_W;
   localparam logic [LW-1:0] LEN_LIMIT = LW'(WORD_MAX);

   sts_pkg::mode_type                mode_ff, mode_in;
   logic [sts_pkg::LEN_W-1:0]        len_ff, len_in;
   logic [sts_pkg::POS_W-1:0]        line_ff, line_in, col_ff, col_in;
   logic [sts_pkg::KW_NUM-1:0]       alive_ff, alive_in;
   logic                             accept;
   logic                             is_digit, is_num, push;
   logic                             num_end;
   logic [sts_pkg::LEN_W-1:0]        base_len;
   logic                             pend_ff, pend_in;
   logic [7:0]                       pend_byte_ff, pend_byte_in;
   logic [4:0]                       pk;
   logic [sts_pkg::KW_NUM-1:0]       hit, done;

   assign req_stall = q_full || q_store_busy || pend_ff;
   assign accept    = req_valid && !req_stall;
   assign is_digit  = (req_char_code >= sts_pkg::CH_ZERO) && (req_char_code <= sts_pkg::CH_NINE);
   assign is_num    = is_digit || (req_char_code == sts_pkg::CH_DOT);
   assign pk        = sts_pkg::punct_kind(req_char_code);
   // a byte that ends a number starts from an empty word
   assign num_end   = (mode_ff == sts_pkg::MODE_NUM) && !is_num;
   assign base_len  = num_end ? '0 : len_ff;

   // running keyword match, one bit per keyword, against the pending word
   always_comb begin
      for (int k = 0; k < sts_pkg::KW_NUM; k++) begin
         hit[k] = ((base_len == '0) || alive_ff[k])
                  && (base_len < LW'(sts_pkg::KW_LEN[k]))
                  && (sts_pkg::KW_CHARS[k][base_len[3:0]] == req_char_code);
         done[k] = hit[k] && ((base_len + 1'b1) == LW'(sts_pkg::KW_LEN[k]));
      end
   end

   always_comb begin
      mode_in  = mode_ff;
      len_in   = len_ff;
      line_in  = line_ff;
      col_in   = col_ff;
      alive_in = alive_ff;
      push     = 1'b0;
      cmd      = '0;
      cmd.flush_line = line_ff;
      cmd.flush_col  = col_ff;

      if (mode_ff != sts_pkg::MODE_HALT) begin
         // a number ends before the byte that ends it, at the old position
         if (num_end) begin
            cmd.flush_en   = 1'b1;
            cmd.flush_kind = sts_pkg::KIND_NUMBER;
            cmd.flush_len  = len_ff;
            len_in  = '0;
            mode_in = sts_pkg::MODE_WORD;
         end

         if (mode_in == sts_pkg::MODE_LIT) begin
            col_in = sts_pkg::sat_inc(col_ff);
            if (req_char_code == sts_pkg::CH_QUOTE) begin
               cmd.flush_en   = (len_ff != '0);
               cmd.flush_kind = sts_pkg::KIND_WORD;
               cmd.flush_len  = len_ff;
               cmd.flush_line = line_in;
               cmd.flush_col  = col_in;
               len_in  = '0;
               mode_in = sts_pkg::MODE_WORD;
            end else if (len_ff >= LEN_LIMIT) begin
               cmd.err_code = sts_pkg::ERR_OVERFLOW;
            end else begin
               push = 1'b1;
            end
         end else if (mode_in == sts_pkg::MODE_NUM) begin
            col_in = sts_pkg::sat_inc(col_ff);
            if (len_ff >= LEN_LIMIT) begin
               cmd.err_code = sts_pkg::ERR_OVERFLOW;
            end else begin
               push = 1'b1;
            end
         end else if (req_char_code == sts_pkg::CH_SPACE || req_char_code == sts_pkg::CH_TAB) begin
            col_in = sts_pkg::sat_inc(col_ff);
         end else begin
            if (req_char_code == sts_pkg::CH_NEWLINE) begin
               line_in = sts_pkg::sat_inc(line_ff);
               col_in  = 16'd1;
            end else begin
               col_in = sts_pkg::sat_inc(col_ff);
            end
            if (pk != sts_pkg::KIND_WORD || req_char_code == sts_pkg::CH_QUOTE) begin
               if (len_in != '0) begin
                  cmd.flush_en   = 1'b1;
                  cmd.flush_kind = sts_pkg::KIND_WORD;
                  cmd.flush_len  = len_in;
                  cmd.flush_line = line_in;
                  cmd.flush_col  = col_in;
               end
               len_in = '0;
               if (req_char_code == sts_pkg::CH_QUOTE) begin
                  mode_in = sts_pkg::MODE_LIT;
               end else begin
                  cmd.single_en   = 1'b1;
                  cmd.single_kind = pk;
                  cmd.single_byte = req_char_code;
               end
            end else if (is_digit) begin
               if (len_in != '0) begin
                  cmd.err_code = sts_pkg::ERR_DIGIT;
               end else begin
                  push    = 1'b1;
                  mode_in = sts_pkg::MODE_NUM;
               end
            end else if (len_in >= LEN_LIMIT) begin
               cmd.err_code = sts_pkg::ERR_OVERFLOW;
            end else begin
               push     = 1'b1;
               alive_in = hit;
               for (int k = sts_pkg::KW_NUM - 1; k >= 0; k--) begin
                  if (done[k]) begin
                     cmd.flush_en   = 1'b1;
                     cmd.flush_kind = sts_pkg::KIND_KW_BASE + 5'(k);
                     cmd.flush_len  = base_len + 1'b1;
                     cmd.flush_line = line_in;
                     cmd.flush_col  = col_in;
                  end
               end
            end
         end

         if (push) begin
            len_in = base_len + 1'b1;
         end
         if (|done && push && mode_in == sts_pkg::MODE_WORD) begin
            len_in = '0;
         end

         cmd.line = line_in;
         cmd.col  = col_in;

         if (cmd.err_code == sts_pkg::ERR_NONE && req_final_byte) begin
            if (mode_in == sts_pkg::MODE_NUM) begin
               cmd.flush_en   = 1'b1;
               cmd.flush_kind = sts_pkg::KIND_NUMBER;
               cmd.flush_len  = len_in;
               cmd.flush_line = line_in;
               cmd.flush_col  = col_in;
            end else if (mode_in == sts_pkg::MODE_LIT || len_in != '0) begin
               cmd.err_code = sts_pkg::ERR_UNFINISH;
            end
            if (cmd.err_code == sts_pkg::ERR_NONE) begin
               mode_in = sts_pkg::MODE_WORD;
               len_in  = '0;
               line_in = '0;
               col_in  = '0;
            end
         end

         if (cmd.err_code != sts_pkg::ERR_NONE) begin
            mode_in = sts_pkg::MODE_HALT;
         end
      end
   end

   // a word byte that ends a number waits until the number has left the store
   assign pend_in      = (accept && push && num_end) || (pend_ff && q_store_busy);
   assign pend_byte_in = accept ? req_char_code : pend_byte_ff;

   assign cmd_valid = accept && (cmd.flush_en || cmd.single_en
                                 || cmd.err_code != sts_pkg::ERR_NONE);
   assign wr_en     = (accept && push && !num_end) || (pend_ff && !q_store_busy);
   assign wr_addr   = pend_ff ? '0 : base_len[AW-1:0];
   assign wr_data   = pend_ff ? pend_byte_ff : req_char_code;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= sts_pkg::MODE_WORD;
         len_ff   <= '0;
         line_ff  <= '0;
         col_ff   <= '0;
         alive_ff <= '0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         len_ff   <= len_in;
         line_ff  <= line_in;
         col_ff   <= col_in;
         alive_ff <= alive_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_byte_ff <= pend_byte_in;
   end

endmodule

@@ hdl/sts_queue.sv @@
module sts_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  sts_pkg::cmd_type push_cmd,
   output logic             full,
   output logic             store_busy,
   output logic             head_valid,
   output sts_pkg::cmd_type head_cmd,
   input  logic             pop
);

   sts_pkg::cmd_type entry_ff [2];
   logic [1:0]       valid_ff, valid_in;
   logic             wr_ptr_ff, rd_ptr_ff;

   assign full       = &valid_ff;
   assign head_valid = valid_ff[rd_ptr_ff];
   assign head_cmd   = entry_ff[rd_ptr_ff];
   // a pending flush still has to read the word store
   assign store_busy = (valid_ff[0] && entry_ff[0].flush_en)
                       || (valid_ff[1] && entry_ff[1].flush_en);

   always_comb begin
      valid_in = valid_ff;
      if (push) begin
         valid_in[wr_ptr_ff] = 1'b1;
      end
      if (pop) begin
         valid_in[rd_ptr_ff] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

endmodule

@@ hdl/sts_back.sv @@
module sts_back #(
   parameter int WORD_MAX = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        head_valid,
   input  sts_pkg::cmd_type            head_cmd,
   output logic                        pop,
   output logic [$clog2(WORD_MAX)-1:0] rd_addr,
   input  logic [7:0]                  rd_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [4:0]                  rsp_token_kind,
   output logic [7:0]                  rsp_content_byte,
   output logic [15:0]                 rsp_line_number,
   output logic [15:0]                 rsp_column_number,
   output logic                        rsp_token_end,
   output logic [1:0]                  rsp_error_code,
   output logic                        rsp_run_last
);

   localparam int AW = $clog2(WORD_MAX);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_FLUSH  = 4'b0010,
      ST_SINGLE = 4'b0100,
      ST_ERR    = 4'b1000
   } state_type;

   state_type                 state_ff, state_in;
   logic [sts_pkg::LEN_W-1:0] idx_ff, idx_in, idx_next;
   logic                      out_free, emit, last_byte, has_err;
   logic                      valid_ff, valid_in;
   logic [4:0]                kind_ff, kind_in;
   logic [7:0]                byte_ff, byte_in;
   logic [15:0]               line_ff, line_in, col_ff, col_in;
   logic                      end_ff, end_in, run_ff, run_in;
   logic [1:0]                err_ff, err_in;

   assign out_free  = !valid_ff || !rsp_stall;
   assign has_err   = head_cmd.err_code != sts_pkg::ERR_NONE;
   assign idx_next  = idx_ff + 1'b1;
   assign last_byte = idx_next == head_cmd.flush_len;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      emit     = 1'b0;
      pop      = 1'b0;
      kind_in  = kind_ff;
      byte_in  = byte_ff;
      line_in  = line_ff;
      col_in   = col_ff;
      end_in   = end_ff;
      run_in   = run_ff;
      err_in   = err_ff;
      rd_addr  = '0;
      case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
            if (head_valid) begin
               if (head_cmd.flush_en) begin
                  state_in = ST_FLUSH;
               end else if (head_cmd.single_en) begin
                  state_in = ST_SINGLE;
               end else begin
                  state_in = ST_ERR;
               end
            end
         end
         ST_FLUSH: begin
            rd_addr = idx_ff[AW-1:0];
            if (out_free) begin
               emit    = 1'b1;
               kind_in = head_cmd.flush_kind;
               byte_in = rd_data;
               line_in = head_cmd.flush_line;
               col_in  = head_cmd.flush_col;
               end_in  = last_byte;
               err_in  = sts_pkg::ERR_NONE;
               run_in  = last_byte && !head_cmd.single_en && !has_err;
               if (last_byte) begin
                  if (head_cmd.single_en) begin
                     state_in = ST_SINGLE;
                  end else if (has_err) begin
                     state_in = ST_ERR;
                  end else begin
                     state_in = ST_IDLE;
                     pop      = 1'b1;
                  end
               end else begin
                  idx_in  = idx_next;
                  rd_addr = idx_next[AW-1:0];
               end
            end
         end
         ST_SINGLE: begin
            if (out_free) begin
               emit    = 1'b1;
               kind_in = head_cmd.single_kind;
               byte_in = head_cmd.single_byte;
               line_in = head_cmd.line;
               col_in  = head_cmd.col;
               end_in  = 1'b1;
               err_in  = sts_pkg::ERR_NONE;
               run_in  = !has_err;
               if (has_err) begin
                  state_in = ST_ERR;
               end else begin
                  state_in = ST_IDLE;
                  pop      = 1'b1;
               end
            end
         end
         ST_ERR: begin
            if (out_free) begin
               emit     = 1'b1;
               kind_in  = sts_pkg::KIND_WORD;
               byte_in  = '0;
               line_in  = head_cmd.line;
               col_in   = head_cmd.col;
               end_in   = 1'b0;
               err_in   = head_cmd.err_code;
               run_in   = 1'b1;
               state_in = ST_IDLE;
               pop      = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      valid_in = emit || (valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      byte_ff <= byte_in;
      line_ff <= line_in;
      col_ff  <= col_in;
      end_ff  <= end_in;
      run_ff  <= run_in;
      err_ff  <= err_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_token_kind    = kind_ff;
   assign rsp_content_byte  = byte_ff;
   assign rsp_line_number   = line_ff;
   assign rsp_column_number = col_ff;
   assign rsp_token_end     = end_ff;
   assign rsp_error_code    = err_ff;
   assign rsp_run_last      = run_ff;

endmodule

@@ hdl/script_token_scanner_unit.sv @@
// Script token scanner: takes one byte of script text per transfer and emits
// each token as a run of content-byte results carrying kind, line and column.
// The front end classifies a byte combinationally and queues what it causes; the
// back end takes each queued entry in its idle state and then emits one result
// per cycle while the result side does not stall, reading pending word bytes
// from the word store one per cycle. The input is held while the two-entry
// queue is full, while a queued entry still has a token to flush from the word
// store, and while a word byte that ended a number waits to be written to it.
// A byte that only emits a single-byte token or an error queues one entry; a
// byte that emits nothing queues nothing. Stalls on the result side hold the
// back end and, once the queue fills, the input.
// An error result halts the scanner until reset; later bytes are taken and dropped.
module script_token_scanner_unit #(
   parameter int WORD_MAX = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_code,
   input  logic        req_final_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_token_kind,
   output logic [7:0]  rsp_content_byte,
   output logic [15:0] rsp_line_number,
   output logic [15:0] rsp_column_number,
   output logic        rsp_token_end,
   output logic [1:0]  rsp_error_code,
   output logic        rsp_run_last
);

   localparam int AW = $clog2(WORD_MAX);

   sts_pkg::cmd_type cmd, head_cmd;
   logic             cmd_valid, q_full, q_store_busy, head_valid, pop;
   logic             wr_en;
   logic [AW-1:0]    wr_addr, rd_addr;
   logic [7:0]       wr_data, rd_data;

   sts_front #(.WORD_MAX(WORD_MAX)) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_char_code  (req_char_code),
      .req_final_byte (req_final_byte),
      .q_full         (q_full),
      .q_store_busy   (q_store_busy),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd),
      .wr_en          (wr_en),
      .wr_addr        (wr_addr),
      .wr_data        (wr_data)
   );

   sts_ram #(.WIDTH(8), .DEPTH(WORD_MAX)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sts_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (cmd_valid),
      .push_cmd   (cmd),
      .full       (q_full),
      .store_busy (q_store_busy),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop)
   );

   sts_back #(.WORD_MAX(WORD_MAX)) u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (head_valid),
      .head_cmd          (head_cmd),
      .pop               (pop),
      .rd_addr           (rd_addr),
      .rd_data           (rd_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_token_kind    (rsp_token_kind),
      .rsp_content_byte  (rsp_content_byte),
      .rsp_line_number   (rsp_line_number),
      .rsp_column_number (rsp_column_number),
      .rsp_token_end     (rsp_token_end),
      .rsp_error_code    (rsp_error_code),
      .rsp_run_last      (rsp_run_last)
   );

endmodule
